// ===== sv/mtis_pkg.sv =====
// ---------------------------------------------------------------------------
// mtis_pkg
// Shared types, operation codes and helpers for the intercept solver.
// ---------------------------------------------------------------------------
package mtis_pkg;

   // depth of the queue between front and back
   localparam int MTIS_QUEUE_DEPTH = 4;

   // shared arithmetic unit operations
   typedef logic [1:0] op_type;
   localparam op_type OP_MUL  = 2'd0;
   localparam op_type OP_DIV  = 2'd1;
   localparam op_type OP_SQRT = 2'd2;

   // rounded quotients clamp to this magnitude
   localparam logic [127:0] DIV_LIMIT = 128'h0000_0000_0000_0000_4000_0000_0000_0000;

   // request to the arithmetic unit
   typedef struct packed {
      logic         go;
      op_type       op;
      logic [127:0] a;
      logic [63:0]  b;
   } ar_req_type;

   // answer from the arithmetic unit
   typedef struct packed {
      logic         done;
      logic [127:0] res;
   } ar_rsp_type;

   // one classified query
   typedef struct packed {
      logic               special;
      logic signed [31:0] sx;
      logic signed [31:0] sy;
      logic signed [32:0] d;
      logic signed [32:0] e;
      logic signed [32:0] r;
      logic signed [32:0] j;
      logic [23:0]        v1;
      logic [23:0]        v2;
      logic [30:0]        dly;
   } entry_type;

   // saturate to the signed 32 bit range
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return v[31:0];
      end
   endfunction

endpackage

// ===== sv/mtis_arith.sv =====
// ---------------------------------------------------------------------------
// mtis_arith
// Shared iterative unit: shift-add multiply, restoring divide, bitwise root.
// ---------------------------------------------------------------------------
module mtis_arith import mtis_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  ar_req_type req,
   output ar_rsp_type rsp
);

   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   op_type       op_ff, op_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic [127:0] acc_ff, acc_in;
   logic [127:0] a_ff, a_in;
   logic [63:0]  b_ff, b_in;
   logic [67:0]  rem_ff, rem_in;
   logic [64:0]  dsh;
   logic [67:0]  rsh;
   logic [67:0]  trial;
   logic         last;

   // one step of the selected operation per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      rem_in  = rem_ff;
      dsh     = '0;
      rsh     = '0;
      trial   = '0;
      last    = (cnt_ff == 7'd0);
      if (req.go) begin
         busy_in = 1'b1;
         op_in   = req.op;
         a_in    = req.a;
         b_in    = req.b;
         acc_in  = '0;
         rem_in  = '0;
         cnt_in  = (req.op == OP_SQRT) ? 7'd63 : 7'd127;
      end else if (busy_ff) begin
         unique case (op_ff)
            OP_MUL: begin
               if (b_ff == '0) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end else begin
                  if (b_ff[0]) acc_in = acc_ff + a_ff;
                  a_in = {a_ff[126:0], 1'b0};
                  b_in = {1'b0, b_ff[63:1]};
               end
            end
            OP_DIV: begin
               dsh = {rem_ff[63:0], a_ff[127]};
               if (dsh >= {1'b0, b_ff}) begin
                  rem_in = {3'b0, dsh - {1'b0, b_ff}};
                  acc_in = {acc_ff[126:0], 1'b1};
               end else begin
                  rem_in = {3'b0, dsh};
                  acc_in = {acc_ff[126:0], 1'b0};
               end
               a_in = {a_ff[126:0], 1'b0};
               if (last) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end else begin
                  cnt_in = cnt_ff - 7'd1;
               end
            end
            OP_SQRT: begin
               rsh   = {rem_ff[65:0], a_ff[127:126]};
               trial = {2'b0, acc_ff[63:0], 2'b01};
               if (rsh >= trial) begin
                  rem_in = rsh - trial;
                  acc_in = {acc_ff[126:0], 1'b1};
               end else begin
                  rem_in = rsh;
                  acc_in = {acc_ff[126:0], 1'b0};
               end
               a_in = {a_ff[125:0], 2'b00};
               if (last) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end else begin
                  cnt_in = cnt_ff - 7'd1;
               end
            end
            default: begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      rem_ff <= rem_in;
   end

   assign rsp.done = done_ff;
   assign rsp.res  = acc_ff;

endmodule

// ===== sv/mtis_fifo.sv =====
// ---------------------------------------------------------------------------
// mtis_fifo
// Small register queue of classified queries between front and back.
// ---------------------------------------------------------------------------
module mtis_fifo import mtis_pkg::*; #(
   parameter int DEPTH = MTIS_QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type wr_data,
   input  logic      pop,
   output entry_type rd_data,
   output logic      full,
   output logic      empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type       mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   cnt_ff, cnt_in;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + CW'(1);
         2'b01:   cnt_in = cnt_ff - CW'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= wr_data;
   end

   assign rd_data = mem_ff[rd_ptr_ff];
   assign full    = (cnt_ff == CW'(DEPTH));
   assign empty   = (cnt_ff == '0);

endmodule

// ===== sv/mtis_front.sv =====
// ---------------------------------------------------------------------------
// mtis_front
// Accepts queries, forms the path and shooter offsets, flags trivial cases.
// ---------------------------------------------------------------------------
module mtis_front import mtis_pkg::*; (
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_target_start_x,
   input  logic signed [31:0] req_target_start_y,
   input  logic signed [31:0] req_target_end_x,
   input  logic signed [31:0] req_target_end_y,
   input  logic [23:0]        req_target_speed,
   input  logic               req_target_speed_infinite,
   input  logic signed [31:0] req_shooter_x,
   input  logic signed [31:0] req_shooter_y,
   input  logic [23:0]        req_missile_speed,
   input  logic               req_missile_speed_infinite,
   input  logic [30:0]        req_launch_delay,
   input  logic               q_full,
   output logic               push,
   output entry_type          entry
);

   // offsets and classification
   always_comb begin
      entry.sx  = req_target_start_x;
      entry.sy  = req_target_start_y;
      entry.d   = 33'(req_target_end_x) - 33'(req_target_start_x);
      entry.e   = 33'(req_target_end_y) - 33'(req_target_start_y);
      entry.r   = 33'(req_shooter_x) - 33'(req_target_start_x);
      entry.j   = 33'(req_shooter_y) - 33'(req_target_start_y);
      entry.v1  = req_target_speed;
      entry.v2  = req_missile_speed;
      entry.dly = req_launch_delay;
      entry.special = req_target_speed_infinite | req_missile_speed_infinite
                    | ((entry.d == '0) && (entry.e == '0));
   end

   assign busy = q_full;
   assign push = start & ~q_full;

endmodule

// ===== sv/mtis_back.sv =====
// ---------------------------------------------------------------------------
// mtis_back
// Sequencer that solves one query at a time on the shared arithmetic unit.
// ---------------------------------------------------------------------------
module mtis_back import mtis_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  entry_type          head,
   input  logic               q_empty,
   output logic               pop,
   output ar_req_type         ar_req,
   input  ar_rsp_type         ar_rsp,
   output logic               rsp_valid,
   output logic               rsp_found,
   output logic signed [31:0] rsp_meet_time,
   output logic signed [31:0] rsp_meet_x,
   output logic signed [31:0] rsp_meet_y
);

   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_D2A  = 5'd1;
   localparam logic [4:0] ST_D2B  = 5'd2;
   localparam logic [4:0] ST_LEN  = 5'd3;
   localparam logic [4:0] ST_DOTA = 5'd4;
   localparam logic [4:0] ST_DOTB = 5'd5;
   localparam logic [4:0] ST_PROJ = 5'd6;
   localparam logic [4:0] ST_CCA  = 5'd7;
   localparam logic [4:0] ST_CCB  = 5'd8;
   localparam logic [4:0] ST_AAA  = 5'd9;
   localparam logic [4:0] ST_AAB  = 5'd10;
   localparam logic [4:0] ST_BP   = 5'd11;
   localparam logic [4:0] ST_LIN  = 5'd12;
   localparam logic [4:0] ST_X    = 5'd13;
   localparam logic [4:0] ST_AC   = 5'd14;
   localparam logic [4:0] ST_S    = 5'd15;
   localparam logic [4:0] ST_TA   = 5'd16;
   localparam logic [4:0] ST_TB   = 5'd17;
   localparam logic [4:0] ST_VT   = 5'd18;
   localparam logic [4:0] ST_MXM  = 5'd19;
   localparam logic [4:0] ST_MXD  = 5'd20;
   localparam logic [4:0] ST_MYM  = 5'd21;
   localparam logic [4:0] ST_MYD  = 5'd22;

   logic [4:0]          state_ff, state_in;
   logic                go_ff, go_in;
   entry_type           ent_ff, ent_in;
   logic [127:0]        wide_ff, wide_in;
   logic [40:0]         len_ff, len_in;
   logic signed [35:0]  proj_ff, proj_in;
   logic [65:0]         cc_ff, cc_in;
   logic signed [48:0]  aa_ff, aa_in;
   logic signed [59:0]  bp_ff, bp_in;
   logic [59:0]         s_ff, s_in;
   logic signed [31:0]  ta_ff, ta_in;
   logic signed [31:0]  t_ff, t_in;
   logic signed [56:0]  vt_ff, vt_in;
   logic signed [31:0]  mx_ff, mx_in;
   logic                valid_ff, valid_in;
   logic                found_ff, found_in;
   logic signed [31:0]  otime_ff, otime_in;
   logic signed [31:0]  ox_ff, ox_in;
   logic signed [31:0]  oy_ff, oy_in;

   logic signed [127:0] ma;
   logic signed [63:0]  mb;
   op_type              op_sel;
   logic [127:0]        ma_mag;
   logic [63:0]         mb_mag;
   logic                neg;
   logic signed [127:0] sp;
   logic [62:0]         m63;
   logic signed [63:0]  sres;
   logic signed [31:0]  sres_sat;
   logic signed [60:0]  bp_ms;
   logic signed [60:0]  bp_ps;
   logic signed [31:0]  dly_s;
   logic                v2_zero;
   logic                va;
   logic                vb;
   logic                ta_ge;
   logic                tb_ge;
   logic signed [31:0]  t_pick;

   assign bp_ms   = 61'(bp_ff) - $signed({1'b0, s_ff});
   assign bp_ps   = 61'(bp_ff) + $signed({1'b0, s_ff});
   assign dly_s   = $signed({1'b0, ent_ff.dly});
   assign v2_zero = (ent_ff.v2 == '0);

   // operand selection per step
   always_comb begin
      ma     = '0;
      mb     = '0;
      op_sel = OP_MUL;
      unique case (state_ff)
         ST_D2A:  begin ma = 128'(ent_ff.d); mb = 64'(ent_ff.d); end
         ST_D2B:  begin ma = 128'(ent_ff.e); mb = 64'(ent_ff.e); end
         ST_LEN:  begin ma = $signed({wide_ff[111:0], 16'b0}); op_sel = OP_SQRT; end
         ST_DOTA: begin ma = 128'(ent_ff.r); mb = 64'(ent_ff.d); end
         ST_DOTB: begin ma = 128'(ent_ff.j); mb = 64'(ent_ff.e); end
         ST_PROJ: begin
            ma     = $signed({wide_ff[119:0], 8'b0});
            mb     = $signed({23'b0, len_ff});
            op_sel = OP_DIV;
         end
         ST_CCA:  begin ma = 128'(ent_ff.r); mb = 64'(ent_ff.r); end
         ST_CCB:  begin ma = 128'(ent_ff.j); mb = 64'(ent_ff.j); end
         ST_AAA:  begin ma = $signed({104'b0, ent_ff.v1}); mb = $signed({40'b0, ent_ff.v1}); end
         ST_AAB:  begin ma = $signed({104'b0, ent_ff.v2}); mb = $signed({40'b0, ent_ff.v2}); end
         ST_BP:   begin ma = 128'(proj_ff); mb = $signed({40'b0, ent_ff.v1}); end
         ST_LIN:  begin
            ma     = $signed({47'b0, cc_ff, 15'b0});
            mb     = 64'(bp_ff);
            op_sel = OP_DIV;
         end
         ST_X:    begin ma = 128'(bp_ff); mb = 64'(bp_ff); end
         ST_AC:   begin ma = $signed({62'b0, cc_ff}); mb = 64'(aa_ff); end
         ST_S:    begin ma = $signed(wide_ff); op_sel = OP_SQRT; end
         ST_TA:   begin ma = 128'(bp_ms) <<< 16; mb = 64'(aa_ff); op_sel = OP_DIV; end
         ST_TB:   begin ma = 128'(bp_ps) <<< 16; mb = 64'(aa_ff); op_sel = OP_DIV; end
         ST_VT:   begin ma = 128'(t_ff); mb = $signed({40'b0, ent_ff.v1}); end
         ST_MXM:  begin ma = 128'(vt_ff); mb = 64'(ent_ff.d); end
         ST_MXD:  begin
            ma     = $signed(wide_ff);
            mb     = $signed({15'b0, len_ff, 8'b0});
            op_sel = OP_DIV;
         end
         ST_MYM:  begin ma = 128'(vt_ff); mb = 64'(ent_ff.e); end
         ST_MYD:  begin
            ma     = $signed(wide_ff);
            mb     = $signed({15'b0, len_ff, 8'b0});
            op_sel = OP_DIV;
         end
         default: begin ma = '0; mb = '0; op_sel = OP_MUL; end
      endcase
   end

   // signs and magnitudes; rounding bias for divides
   assign ma_mag = ma[127] ? $unsigned(-ma) : $unsigned(ma);
   assign mb_mag = mb[63] ? $unsigned(-mb) : $unsigned(mb);
   assign neg    = ma[127] ^ mb[63];

   assign ar_req.go = go_ff;
   assign ar_req.op = op_sel;
   assign ar_req.a  = (op_sel == OP_DIV) ? ma_mag + {65'b0, mb_mag[63:1]} : ma_mag;
   assign ar_req.b  = mb_mag;

   // signed product and clamped signed quotient
   assign sp       = neg ? -$signed(ar_rsp.res) : $signed(ar_rsp.res);
   assign m63      = (ar_rsp.res > DIV_LIMIT) ? DIV_LIMIT[62:0] : ar_rsp.res[62:0];
   assign sres     = neg ? -$signed({1'b0, m63}) : $signed({1'b0, m63});
   assign sres_sat = sat32(sres);

   // root choice once the later root is known
   always_comb begin
      va     = v2_zero || !ta_ff[31];
      vb     = v2_zero || !sres_sat[31];
      ta_ge  = (ta_ff >= dly_s);
      tb_ge  = (sres_sat >= dly_s);
      t_pick = ta_ff;
      if (vb) begin
         if (ta_ge && tb_ge) begin
            t_pick = (ta_ff < sres_sat) ? ta_ff : sres_sat;
         end else if (tb_ge) begin
            t_pick = sres_sat;
         end
      end
   end

   // step sequencer
   always_comb begin
      state_in = state_ff;
      go_in    = 1'b0;
      ent_in   = ent_ff;
      wide_in  = wide_ff;
      len_in   = len_ff;
      proj_in  = proj_ff;
      cc_in    = cc_ff;
      aa_in    = aa_ff;
      bp_in    = bp_ff;
      s_in     = s_ff;
      ta_in    = ta_ff;
      t_in     = t_ff;
      vt_in    = vt_ff;
      mx_in    = mx_ff;
      valid_in = 1'b0;
      found_in = found_ff;
      otime_in = otime_ff;
      ox_in    = ox_ff;
      oy_in    = oy_ff;
      pop      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               pop    = 1'b1;
               ent_in = head;
               if (head.special) begin
                  valid_in = 1'b1;
                  found_in = 1'b1;
                  otime_in = '0;
                  ox_in    = head.sx;
                  oy_in    = head.sy;
               end else begin
                  state_in = ST_D2A;
                  go_in    = 1'b1;
               end
            end
         end
         ST_D2A: if (ar_rsp.done) begin
            wide_in = ar_rsp.res; state_in = ST_D2B; go_in = 1'b1;
         end
         ST_D2B: if (ar_rsp.done) begin
            wide_in = wide_ff + ar_rsp.res; state_in = ST_LEN; go_in = 1'b1;
         end
         ST_LEN: if (ar_rsp.done) begin
            len_in = ar_rsp.res[40:0]; state_in = ST_DOTA; go_in = 1'b1;
         end
         ST_DOTA: if (ar_rsp.done) begin
            wide_in = sp; state_in = ST_DOTB; go_in = 1'b1;
         end
         ST_DOTB: if (ar_rsp.done) begin
            wide_in = $unsigned($signed(wide_ff) + sp); state_in = ST_PROJ; go_in = 1'b1;
         end
         ST_PROJ: if (ar_rsp.done) begin
            proj_in = sres[35:0]; state_in = ST_CCA; go_in = 1'b1;
         end
         ST_CCA: if (ar_rsp.done) begin
            cc_in = ar_rsp.res[65:0]; state_in = ST_CCB; go_in = 1'b1;
         end
         ST_CCB: if (ar_rsp.done) begin
            cc_in = cc_ff + ar_rsp.res[65:0]; state_in = ST_AAA; go_in = 1'b1;
         end
         ST_AAA: if (ar_rsp.done) begin
            aa_in = $signed({1'b0, ar_rsp.res[47:0]}); state_in = ST_AAB; go_in = 1'b1;
         end
         ST_AAB: if (ar_rsp.done) begin
            aa_in = aa_ff - $signed({1'b0, ar_rsp.res[47:0]}); state_in = ST_BP; go_in = 1'b1;
         end
         ST_BP: if (ar_rsp.done) begin
            bp_in = sp[59:0];
            if (aa_ff != '0) begin
               state_in = ST_X; go_in = 1'b1;
            end else if (sp[59:0] != '0) begin
               state_in = ST_LIN; go_in = 1'b1;
            end else begin
               // degenerate: meet only when the shooter sits on the start point
               state_in = ST_IDLE;
               valid_in = 1'b1;
               found_in = (cc_ff == '0);
               otime_in = '0;
               ox_in    = (cc_ff == '0) ? ent_ff.sx : '0;
               oy_in    = (cc_ff == '0) ? ent_ff.sy : '0;
            end
         end
         ST_LIN: if (ar_rsp.done) begin
            t_in = sres_sat;
            if (v2_zero || !sres_sat[31]) begin
               state_in = ST_VT; go_in = 1'b1;
            end else begin
               state_in = ST_IDLE; valid_in = 1'b1; found_in = 1'b0;
               otime_in = '0; ox_in = '0; oy_in = '0;
            end
         end
         ST_X: if (ar_rsp.done) begin
            wide_in = ar_rsp.res; state_in = ST_AC; go_in = 1'b1;
         end
         ST_AC: if (ar_rsp.done) begin
            if (!aa_ff[48] && (wide_ff < ar_rsp.res)) begin
               // negative discriminant
               state_in = ST_IDLE; valid_in = 1'b1; found_in = 1'b0;
               otime_in = '0; ox_in = '0; oy_in = '0;
            end else begin
               wide_in  = aa_ff[48] ? wide_ff + ar_rsp.res : wide_ff - ar_rsp.res;
               state_in = ST_S; go_in = 1'b1;
            end
         end
         ST_S: if (ar_rsp.done) begin
            s_in = ar_rsp.res[59:0]; state_in = ST_TA; go_in = 1'b1;
         end
         ST_TA: if (ar_rsp.done) begin
            ta_in = sres_sat; state_in = ST_TB; go_in = 1'b1;
         end
         ST_TB: if (ar_rsp.done) begin
            if (va) begin
               t_in = t_pick; state_in = ST_VT; go_in = 1'b1;
            end else begin
               state_in = ST_IDLE; valid_in = 1'b1; found_in = 1'b0;
               otime_in = '0; ox_in = '0; oy_in = '0;
            end
         end
         ST_VT: if (ar_rsp.done) begin
            vt_in = sp[56:0]; state_in = ST_MXM; go_in = 1'b1;
         end
         ST_MXM: if (ar_rsp.done) begin
            wide_in = $unsigned(sp); state_in = ST_MXD; go_in = 1'b1;
         end
         ST_MXD: if (ar_rsp.done) begin
            mx_in = sat32(64'(ent_ff.sx) + sres); state_in = ST_MYM; go_in = 1'b1;
         end
         ST_MYM: if (ar_rsp.done) begin
            wide_in = $unsigned(sp); state_in = ST_MYD; go_in = 1'b1;
         end
         ST_MYD: if (ar_rsp.done) begin
            state_in = ST_IDLE;
            valid_in = 1'b1;
            found_in = 1'b1;
            otime_in = t_ff;
            ox_in    = mx_ff;
            oy_in    = sat32(64'(ent_ff.sy) + sres);
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         go_ff    <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         go_ff    <= go_in;
         valid_ff <= valid_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      ent_ff   <= ent_in;
      wide_ff  <= wide_in;
      len_ff   <= len_in;
      proj_ff  <= proj_in;
      cc_ff    <= cc_in;
      aa_ff    <= aa_in;
      bp_ff    <= bp_in;
      s_ff     <= s_in;
      ta_ff    <= ta_in;
      t_ff     <= t_in;
      vt_ff    <= vt_in;
      mx_ff    <= mx_in;
      found_ff <= found_in;
      otime_ff <= otime_in;
      ox_ff    <= ox_in;
      oy_ff    <= oy_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_found     = found_ff;
   assign rsp_meet_time = otime_ff;
   assign rsp_meet_x    = ox_ff;
   assign rsp_meet_y    = oy_ff;

endmodule

// ===== sv/moving_target_intercept_solver.sv =====
// ---------------------------------------------------------------------------
// moving_target_intercept_solver
// Solves the 2D intercept quadratic for a target on a straight path.
// ---------------------------------------------------------------------------
//   channel   ports                       transfer
//   query     start/busy, req_*           start high while busy low
//   result    rsp_valid, rsp_*            rsp_valid high, one cycle
//
// Queries with an infinite speed or a zero-length path show their result in
// the cycle after they leave the queue. Every other query runs all of its
// steps on the single shared shift-add multiply, restoring divide and
// bitwise root unit.
// The queue takes new queries while one is solved; busy is high when it is
// full. Synchronous reset empties the queue and drops any query in progress.
// ---------------------------------------------------------------------------
module moving_target_intercept_solver import mtis_pkg::*; #(
   parameter int QUEUE_DEPTH = MTIS_QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_target_start_x,
   input  logic signed [31:0] req_target_start_y,
   input  logic signed [31:0] req_target_end_x,
   input  logic signed [31:0] req_target_end_y,
   input  logic [23:0]        req_target_speed,
   input  logic               req_target_speed_infinite,
   input  logic signed [31:0] req_shooter_x,
   input  logic signed [31:0] req_shooter_y,
   input  logic [23:0]        req_missile_speed,
   input  logic               req_missile_speed_infinite,
   input  logic [30:0]        req_launch_delay,
   output logic               rsp_valid,
   output logic               rsp_found,
   output logic signed [31:0] rsp_meet_time,
   output logic signed [31:0] rsp_meet_x,
   output logic signed [31:0] rsp_meet_y
);

   entry_type  front_entry;
   entry_type  head;
   logic       push;
   logic       pop;
   logic       q_full;
   logic       q_empty;
   ar_req_type ar_req;
   ar_rsp_type ar_rsp;

   // accept and classify
   mtis_front u_front (
      .start                      (start),
      .busy                       (busy),
      .req_target_start_x         (req_target_start_x),
      .req_target_start_y         (req_target_start_y),
      .req_target_end_x           (req_target_end_x),
      .req_target_end_y           (req_target_end_y),
      .req_target_speed           (req_target_speed),
      .req_target_speed_infinite  (req_target_speed_infinite),
      .req_shooter_x              (req_shooter_x),
      .req_shooter_y              (req_shooter_y),
      .req_missile_speed          (req_missile_speed),
      .req_missile_speed_infinite (req_missile_speed_infinite),
      .req_launch_delay           (req_launch_delay),
      .q_full                     (q_full),
      .push                       (push),
      .entry                      (front_entry)
   );

   // queue between front and back
   mtis_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (front_entry),
      .pop     (pop),
      .rd_data (head),
      .full    (q_full),
      .empty   (q_empty)
   );

   // solver sequencer
   mtis_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .q_empty       (q_empty),
      .pop           (pop),
      .ar_req        (ar_req),
      .ar_rsp        (ar_rsp),
      .rsp_valid     (rsp_valid),
      .rsp_found     (rsp_found),
      .rsp_meet_time (rsp_meet_time),
      .rsp_meet_x    (rsp_meet_x),
      .rsp_meet_y    (rsp_meet_y)
   );

   // shared arithmetic
   mtis_arith u_arith (
      .clock (clock),
      .reset (reset),
      .req   (ar_req),
      .rsp   (ar_rsp)
   );

endmodule

// ===== sv/mtis_checker.sv =====
// ---------------------------------------------------------------------------
// mtis_checker
// Port-level checks of the intercept solver, bound to the top level.
// ---------------------------------------------------------------------------
module mtis_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic               rsp_found,
   input logic signed [31:0] rsp_meet_time,
   input logic signed [31:0] rsp_meet_x,
   input logic signed [31:0] rsp_meet_y
);

   // a miss carries an all-zero payload
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |->
         rsp_meet_time == 0 && rsp_meet_x == 0 && rsp_meet_y == 0)
      else $error("miss with nonzero time or point");

   // reset empties the queue and drops pending results
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("busy or result right after reset");

   // the queue only fills through a transfer
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a query transfer");

endmodule

bind moving_target_intercept_solver mtis_checker u_mtis_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the moving-target intercept solver: directed corner
// queries and random queries are driven with random gaps, every result is
// predicted in the bench and compared field by field in transfer order.
// ---------------------------------------------------------------------------
module tb;

   // one query as driven on the req_ ports
   typedef struct packed {
      logic signed [31:0] sx;
      logic signed [31:0] sy;
      logic signed [31:0] ex;
      logic signed [31:0] ey;
      logic [23:0]        v1;
      logic               inf1;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic [23:0]        v2;
      logic               inf2;
      logic [30:0]        dly;
   } intercept_query_type;

   // one result as seen on the rsp_ ports
   typedef struct packed {
      logic               found;
      logic signed [31:0] tm;
      logic signed [31:0] mx;
      logic signed [31:0] my;
   } intercept_answer_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [31:0] req_target_start_x = '0;
   logic signed [31:0] req_target_start_y = '0;
   logic signed [31:0] req_target_end_x = '0;
   logic signed [31:0] req_target_end_y = '0;
   logic [23:0]        req_target_speed = '0;
   logic               req_target_speed_infinite = 1'b0;
   logic signed [31:0] req_shooter_x = '0;
   logic signed [31:0] req_shooter_y = '0;
   logic [23:0]        req_missile_speed = '0;
   logic               req_missile_speed_infinite = 1'b0;
   logic [30:0]        req_launch_delay = '0;
   logic               rsp_valid;
   logic               rsp_found;
   logic signed [31:0] rsp_meet_time;
   logic signed [31:0] rsp_meet_x;
   logic signed [31:0] rsp_meet_y;

   intercept_query_type  pending_queries[$];
   intercept_answer_type expected_answers[$];
   intercept_query_type  cur_query;
   int                   gap_left = 0;
   int                   mismatch_count = 0;
   bit                   stimulus_done = 1'b0;

   moving_target_intercept_solver uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_target_start_x(req_target_start_x),
      .req_target_start_y(req_target_start_y),
      .req_target_end_x(req_target_end_x),
      .req_target_end_y(req_target_end_y),
      .req_target_speed(req_target_speed),
      .req_target_speed_infinite(req_target_speed_infinite),
      .req_shooter_x(req_shooter_x),
      .req_shooter_y(req_shooter_y),
      .req_missile_speed(req_missile_speed),
      .req_missile_speed_infinite(req_missile_speed_infinite),
      .req_launch_delay(req_launch_delay),
      .rsp_valid(rsp_valid),
      .rsp_found(rsp_found),
      .rsp_meet_time(rsp_meet_time),
      .rsp_meet_x(rsp_meet_x),
      .rsp_meet_y(rsp_meet_y)
   );

   // clock
   always #5 clock = ~clock;

   // clamp to the signed 32 bit range
   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // floor square root of a 128 bit unsigned value
   function automatic logic [63:0] floor_root(input logic [127:0] n);
      logic [63:0]  r;
      logic [63:0]  c;
      logic [127:0] sq;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         c = r | (64'd1 << b);
         sq = {64'd0, c} * {64'd0, c};
         if (n >= sq) r = c;
      end
      return r;
   endfunction

   // signed quotient rounded half away from zero, clamped to +-2^62
   function automatic longint div_round(input logic signed [127:0] n,
                                        input logic signed [127:0] dv);
      logic [127:0] mn;
      logic [127:0] md;
      logic [127:0] q;
      bit           neg;
      neg = n[127] ^ dv[127];
      mn = n[127] ? -n : n;
      md = dv[127] ? -dv : dv;
      if (md == 0) return 0;
      q = (mn + (md >> 1)) / md;
      if (q > 128'h4000_0000_0000_0000) q = 128'h4000_0000_0000_0000;
      return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
   endfunction

   // expected result of one query
   function automatic intercept_answer_type solve_intercept(input intercept_query_type q);
      intercept_answer_type a;
      longint             sx, sy, v1, v2, dly, bp, aa, amag, t, ta, tb, s, mx, my, proj, vt;
      logic signed [127:0] dd, ee, rr, jj, d2, cc, w1, w2;
      logic [127:0]       mb, x, ac, disc;
      logic [63:0]        len;
      bit                 found, ok, va, vb;
      sx = q.sx;
      sy = q.sy;
      v1 = q.v1;
      v2 = q.v2;
      dly = q.dly;
      dd = longint'(q.ex) - sx;
      ee = longint'(q.ey) - sy;
      rr = longint'(q.px) - sx;
      jj = longint'(q.py) - sy;
      t = 0;
      mx = 0;
      my = 0;
      found = 1'b0;
      d2 = dd * dd + ee * ee;
      if (d2 == 0 || q.inf1 || q.inf2) begin
         found = 1'b1;
         mx = sx;
         my = sy;
      end else begin
         len = floor_root($unsigned(d2) << 16);
         proj = div_round((rr * dd + jj * ee) <<< 8, {64'd0, len});
         cc = rr * rr + jj * jj;
         aa = v1 * v1 - v2 * v2;
         bp = v1 * proj;
         if (aa == 0) begin
            // linear or fully degenerate equation
            if (bp == 0) begin
               found = (cc == 0);
            end else begin
               w1 = bp;
               t = clamp32(div_round(cc <<< 15, w1));
               found = (v2 == 0 || t >= 0);
            end
         end else begin
            mb = (bp < 0) ? -bp : bp;
            x = mb * mb;
            amag = (aa < 0) ? -aa : aa;
            ac = $unsigned(cc) * amag;
            ok = 1'b1;
            if (aa > 0) begin
               ok = (x >= ac);
               disc = x - ac;
            end else begin
               disc = x + ac;
            end
            if (ok) begin
               s = floor_root(disc);
               w2 = aa;
               w1 = bp - s;
               ta = clamp32(div_round(w1 <<< 16, w2));
               w1 = bp + s;
               tb = clamp32(div_round(w1 <<< 16, w2));
               va = (v2 == 0 || ta >= 0);
               vb = (v2 == 0 || tb >= 0);
               // earlier root unless only the later one clears the delay
               if (va) begin
                  found = 1'b1;
                  t = ta;
                  if (vb) begin
                     if (ta >= dly && tb >= dly) t = (ta < tb) ? ta : tb;
                     else if (tb >= dly) t = tb;
                  end
               end
            end
         end
         if (found) begin
            vt = v1 * t;
            w1 = vt;
            w2 = {64'd0, len << 8};
            mx = clamp32(sx + div_round(w1 * dd, w2));
            my = clamp32(sy + div_round(w1 * ee, w2));
         end else begin
            t = 0;
         end
      end
      a.found = found;
      a.tm = t[31:0];
      a.mx = mx[31:0];
      a.my = my[31:0];
      return a;
   endfunction

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $signed($urandom_range(0, 32'h1ffff)) - 32'sh10000;
         default: return $signed($urandom_range(0, 32'h1ffffff)) - 32'sh1000000;
      endcase
   endfunction

   function automatic logic [23:0] rand_speed();
      case ($urandom_range(0, 3))
         0: return 24'($urandom);
         1: return 24'($urandom_range(0, 16'hffff));
         default: return 24'($urandom_range(0, 24'h3fff));
      endcase
   endfunction

   // random query, mostly well-formed with a few special forms mixed in
   function automatic intercept_query_type rand_query();
      intercept_query_type q;
      q.sx = rand_coord();
      q.sy = rand_coord();
      q.ex = rand_coord();
      q.ey = rand_coord();
      q.px = rand_coord();
      q.py = rand_coord();
      q.v1 = rand_speed();
      q.v2 = rand_speed();
      q.inf1 = ($urandom_range(0, 99) < 4);
      q.inf2 = ($urandom_range(0, 99) < 4);
      case ($urandom_range(0, 3))
         0: q.dly = 31'($urandom);
         1: q.dly = 0;
         default: q.dly = 31'($urandom_range(0, 32'h3ffffff));
      endcase
      if ($urandom_range(0, 99) < 3) begin
         q.ex = q.sx;
         q.ey = q.sy;
      end
      if ($urandom_range(0, 99) < 3) begin
         q.px = q.sx;
         q.py = q.sy;
      end
      if ($urandom_range(0, 99) < 12) q.v2 = q.v1;
      if ($urandom_range(0, 99) < 5) q.v2 = 0;
      if ($urandom_range(0, 99) < 3) q.v1 = 0;
      return q;
   endfunction

   task automatic add_query(input logic signed [31:0] sx, sy, ex, ey,
                            input logic [23:0] v1, input logic inf1,
                            input logic signed [31:0] px, py,
                            input logic [23:0] v2, input logic inf2,
                            input logic [30:0] dly);
      intercept_query_type q;
      q = '{sx, sy, ex, ey, v1, inf1, px, py, v2, inf2, dly};
      pending_queries.push_back(q);
   endtask

   // driver: holds start until the transfer, then moves on after a random gap
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && busy) begin
         start <= 1'b1;
      end else begin
         if (start) expected_answers.push_back(solve_intercept(cur_query));
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (pending_queries.size() > 0) begin
            cur_query = pending_queries.pop_front();
            req_target_start_x <= cur_query.sx;
            req_target_start_y <= cur_query.sy;
            req_target_end_x <= cur_query.ex;
            req_target_end_y <= cur_query.ey;
            req_target_speed <= cur_query.v1;
            req_target_speed_infinite <= cur_query.inf1;
            req_shooter_x <= cur_query.px;
            req_shooter_y <= cur_query.py;
            req_missile_speed <= cur_query.v2;
            req_missile_speed_infinite <= cur_query.inf2;
            req_launch_delay <= cur_query.dly;
            start <= 1'b1;
            case ($urandom_range(0, 19))
               0: gap_left <= $urandom_range(20, 300);
               1, 2, 3, 4, 5: gap_left <= $urandom_range(1, 4);
               default: gap_left <= 0;
            endcase
         end else begin
            start <= 1'b0;
            stimulus_done <= 1'b1;
         end
      end
   end

   // monitor: each result transfer against the oldest expectation
   always @(posedge clock) begin
      intercept_answer_type want;
      if (!reset && rsp_valid) begin
         if (expected_answers.size() == 0) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
               $display("unexpected result: found=%0b time=%0d x=%0d y=%0d",
                        rsp_found, rsp_meet_time, rsp_meet_x, rsp_meet_y);
         end else begin
            want = expected_answers.pop_front();
            if (rsp_found !== want.found || rsp_meet_time !== want.tm ||
                rsp_meet_x !== want.mx || rsp_meet_y !== want.my) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("mismatch: exp found=%0b time=%0d x=%0d y=%0d, got %0b %0d %0d %0d",
                           want.found, want.tm, want.mx, want.my,
                           rsp_found, rsp_meet_time, rsp_meet_x, rsp_meet_y);
            end
         end
      end
   end

   // stimulus, reset and end of run
   initial begin
      // zero path, both infinity flags, degenerate and linear cases
      add_query(32'sd1000, -32'sd500, 32'sd1000, -32'sd500, 24'd300, 1'b0,
                32'sd7000, 32'sd9000, 24'd200, 1'b0, 31'd0);
      add_query(32'sd256, 32'sd512, 32'sd9000, 32'sd512, 24'd100, 1'b1,
                -32'sd4000, 32'sd100, 24'd400, 1'b0, 31'd0);
      add_query(32'sd256, 32'sd512, 32'sd9000, 32'sd512, 24'd100, 1'b0,
                -32'sd4000, 32'sd100, 24'd400, 1'b1, 31'd5);
      add_query(32'sd256, 32'sd512, 32'sd9000, 32'sd512, 24'd0, 1'b0,
                32'sd256, 32'sd512, 24'd0, 1'b0, 31'd0);
      add_query(32'sd256, 32'sd512, 32'sd9000, 32'sd512, 24'd0, 1'b0,
                32'sd3000, 32'sd512, 24'd0, 1'b0, 31'd0);
      add_query(32'sd0, 32'sd0, 32'sd25600, 32'sd0, 24'd512, 1'b0,
                32'sd51200, 32'sd2560, 24'd512, 1'b0, 31'd0);
      add_query(32'sd0, 32'sd0, 32'sd25600, 32'sd0, 24'd512, 1'b0,
                -32'sd51200, 32'sd2560, 24'd512, 1'b0, 31'd0);
      // target faster than projectile, shooter behind: no real root
      add_query(32'sd0, 32'sd0, 32'sd25600, 32'sd0, 24'd2560, 1'b0,
                -32'sd51200, 32'sd25600, 24'd256, 1'b0, 31'd0);
      // two valid roots against different delays
      add_query(32'sd0, 32'sd0, 32'sd25600, 32'sd0, 24'd1024, 1'b0,
                32'sd51200, 32'sd2560, 24'd768, 1'b0, 31'd0);
      add_query(32'sd0, 32'sd0, 32'sd25600, 32'sd0, 24'd1024, 1'b0,
                32'sd51200, 32'sd2560, 24'd768, 1'b0, 31'h0008_0000);
      add_query(32'sd0, 32'sd0, 32'sd25600, 32'sd0, 24'd1024, 1'b0,
                32'sd51200, 32'sd2560, 24'd768, 1'b0, 31'h7fffffff);
      // standing projectile accepts negative times
      add_query(32'sd0, 32'sd0, 32'sd25600, 32'sd0, 24'd1024, 1'b0,
                -32'sd51200, 32'sd0, 24'd0, 1'b0, 31'd0);
      add_query(32'sd0, 32'sd0, 32'sd25600, 32'sd0, 24'd1024, 1'b0,
                32'sd51200, 32'sd0, 24'd0, 1'b0, 31'd0);
      // projectile faster than target
      add_query(32'sd100, -32'sd300, 32'sd5000, 32'sd7000, 24'd256, 1'b0,
                32'sd9000, -32'sd4000, 24'd1000, 1'b0, 31'd65536);
      // field extremes
      add_query(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                24'hffffff, 1'b0, 32'sh7fffffff, 32'sh80000000, 24'hffffff, 1'b0,
                31'h7fffffff);
      add_query(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
                24'hffffff, 1'b0, 32'sh80000000, 32'sh7fffffff, 24'd1, 1'b0, 31'd0);
      add_query(32'sh80000000, 32'sh7fffffff, 32'sh80000001, 32'sh7fffffff,
                24'd1, 1'b0, 32'sh7fffffff, 32'sh80000000, 24'hffffff, 1'b0, 31'd1);
      add_query(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                24'hffffff, 1'b0, 32'sh7fffffff, 32'sh7fffffff, 24'hfffffe, 1'b0,
                31'd0);
      add_query(32'sd0, 32'sd0, 32'sd1, 32'sd0, 24'hffffff, 1'b0,
                32'sh7fffffff, 32'sd0, 24'd0, 1'b0, 31'd0);
      add_query(32'sh80000000, 32'sd0, 32'sh80000000, 32'sd1, 24'hffffff, 1'b1,
                32'sd0, 32'sd0, 24'hffffff, 1'b1, 31'h7fffffff);
      for (int i = 0; i < 1080; i++) pending_queries.push_back(rand_query());

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      wait (stimulus_done);
      wait (expected_answers.size() == 0);
      repeat (2000) @(posedge clock);
      if (mismatch_count == 0 && expected_answers.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // run limit
   initial begin
      #400_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
